[src/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants and round functions for the byte stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  word_index;
        logic [31:0] digest_word;
        logic        last_word;
    } out_beat_t;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } state_t;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428A2F98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hB5C0FBCF; 6'd3:  k = 32'hE9B5DBA5;
            6'd4:  k = 32'h3956C25B; 6'd5:  k = 32'h59F111F1;
            6'd6:  k = 32'h923F82A4; 6'd7:  k = 32'hAB1C5ED5;
            6'd8:  k = 32'hD807AA98; 6'd9:  k = 32'h12835B01;
            6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7; 6'd63: k = 32'hC67178F2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        case (i)
            3'd0: h = 32'h6A09E667; 3'd1: h = 32'hBB67AE85;
            3'd2: h = 32'h3C6EF372; 3'd3: h = 32'hA54FF53A;
            3'd4: h = 32'h510E527F; 3'd5: h = 32'h9B05688C;
            3'd6: h = 32'h1F83D9AB; 3'd7: h = 32'h5BE0CD19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

`default_nettype wire

[src/sha256_byte_stream_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Absorbs message bytes one beat at a time, pads on finish, emits the digest.
// ----------------------------------------------------------------------------
// The 64th byte starts a compression: the round state, then the add state.
// A finish pads one byte a cycle, runs one or two compressions, then shows
// eight output beats. Input is stalled whenever the hasher is not idle.
// Reset (rst_n low, asynchronous) loads the initial hash and clears the counts.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_byte_stream_hasher (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire sha256_pkg::in_beat_t in_data,
    output logic                   out_valid,
    input  wire                    out_stall,
    output sha256_pkg::out_beat_t  out_data
);

    // State registers.
    sha256_pkg::state_t state_reg, state_next;
    logic [31:0] chain_reg [8];
    logic [31:0] work_reg  [8];
    // The block buffer is kept as sixteen 32-bit words; during rounds it is
    // reused as the rolling message schedule.
    logic [31:0] sched_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [5:0]  round_reg;
    logic        final_reg;   // The running compression is the last one of a finish.
    logic [2:0]  emit_reg;

    logic in_fire;
    logic out_fire;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    assign in_stall  = (state_reg != sha256_pkg::ST_IDLE);
    assign out_valid = (state_reg == sha256_pkg::ST_EMIT);

    always_comb
    begin
        out_data.word_index  = emit_reg;
        out_data.digest_word = chain_reg[emit_reg];
        out_data.last_word   = (emit_reg == 3'd7);
    end

    // Round unit: one SHA-256 round per cycle on the working variables. The
    // schedule word for round t sits at index t mod 16 for t < 16 and is built
    // from the rolling window for later rounds.
    logic [3:0]  ridx;
    logic [31:0] w15, w2, w7, w16, sg0, sg1, wt, s0, s1, ch, maj, t1, t2;
    assign ridx = round_reg[3:0];
    always_comb
    begin
        w15 = sched_reg[ridx + 4'd1];
        w2  = sched_reg[ridx + 4'd14];
        w7  = sched_reg[ridx + 4'd9];
        w16 = sched_reg[ridx];
        sg0 = sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3);
        sg1 = sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10);
        wt  = (round_reg < 6'd16) ? w16 : (sg1 + w7 + sg0 + w16);
        s1  = sha256_pkg::rotr(work_reg[4], 6) ^ sha256_pkg::rotr(work_reg[4], 11)
            ^ sha256_pkg::rotr(work_reg[4], 25);
        ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        t1  = work_reg[7] + s1 + ch + sha256_pkg::round_k(round_reg) + wt;
        s0  = sha256_pkg::rotr(work_reg[0], 2) ^ sha256_pkg::rotr(work_reg[0], 13)
            ^ sha256_pkg::rotr(work_reg[0], 22);
        maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
            ^ (work_reg[1] & work_reg[2]);
        t2  = s0 + maj;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (fill_reg == 6'd63)
                    begin
                        // The beat fills the block, whether data or pad byte.
                        state_next = sha256_pkg::ST_ROUND;
                    end
                    else if (in_data.action == sha256_pkg::ACT_FINISH)
                    begin
                        state_next = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD:
            begin
                if (fill_reg == 6'd63)
                begin
                    state_next = sha256_pkg::ST_ROUND;
                end
            end
            sha256_pkg::ST_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = sha256_pkg::ST_ADD;
                end
            end
            sha256_pkg::ST_ADD:
            begin
                if (final_reg)
                begin
                    state_next = sha256_pkg::ST_EMIT;
                end
                else if (bits_reg[0])
                begin
                    // A padding compression that still owes the length block.
                    state_next = sha256_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha256_pkg::ST_IDLE;
                end
            end
            sha256_pkg::ST_EMIT:
            begin
                if (out_fire && emit_reg == 3'd7)
                begin
                    state_next = sha256_pkg::ST_IDLE;
                end
            end
            default: state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    // Padding bookkeeping: bits_reg bit 0 is never set by byte counting, so it
    // marks "finish in progress, length block still owed" once the length is
    // copied into len_reg.
    logic [63:0] len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha256_pkg::ST_IDLE;
            fill_reg  <= '0;
            bits_reg  <= '0;
            len_reg   <= '0;
            round_reg <= '0;
            final_reg <= 1'b0;
            emit_reg  <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sha256_pkg::init_h(3'(i));
                work_reg[i]  <= '0;
            end
            for (int i = 0; i < 16; i++)
            begin
                sched_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                sha256_pkg::ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (in_data.action == sha256_pkg::ACT_ABSORB)
                        begin
                            sched_reg[fill_reg[5:2]][8 * (3 - fill_reg[1:0]) +: 8]
                                <= in_data.data_byte;
                            bits_reg <= bits_reg + 64'd8;
                            fill_reg <= fill_reg + 6'd1;
                        end
                        else
                        begin
                            sched_reg[fill_reg[5:2]][8 * (3 - fill_reg[1:0]) +: 8]
                                <= sha256_pkg::PAD_BYTE;
                            len_reg  <= bits_reg;
                            // Room for the length after the pad byte decides
                            // whether this is the last block.
                            final_reg <= (fill_reg < sha256_pkg::LEN_POS);
                            bits_reg  <= {63'd0, !(fill_reg < sha256_pkg::LEN_POS)};
                            fill_reg  <= fill_reg + 6'd1;
                        end
                        if (fill_reg == 6'd63)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                work_reg[i] <= chain_reg[i];
                            end
                            round_reg <= '0;
                        end
                    end
                end
                sha256_pkg::ST_PAD:
                begin
                    if (fill_reg >= sha256_pkg::LEN_POS && final_reg)
                    begin
                        sched_reg[fill_reg[5:2]][8 * (3 - fill_reg[1:0]) +: 8]
                            <= len_reg[8 * (7 - fill_reg[2:0]) +: 8];
                    end
                    else
                    begin
                        sched_reg[fill_reg[5:2]][8 * (3 - fill_reg[1:0]) +: 8]
                            <= 8'h00;
                    end
                    fill_reg <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            work_reg[i] <= chain_reg[i];
                        end
                        round_reg <= '0;
                    end
                end
                sha256_pkg::ST_ROUND:
                begin
                    sched_reg[ridx] <= wt;
                    work_reg[7] <= work_reg[6];
                    work_reg[6] <= work_reg[5];
                    work_reg[5] <= work_reg[4];
                    work_reg[4] <= work_reg[3] + t1;
                    work_reg[3] <= work_reg[2];
                    work_reg[2] <= work_reg[1];
                    work_reg[1] <= work_reg[0];
                    work_reg[0] <= t1 + t2;
                    round_reg <= round_reg + 6'd1;
                end
                sha256_pkg::ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                    fill_reg <= 6'd0;
                    if (!final_reg && bits_reg[0])
                    begin
                        final_reg <= 1'b1;
                    end
                    emit_reg <= 3'd0;
                end
                sha256_pkg::ST_EMIT:
                begin
                    if (out_fire)
                    begin
                        emit_reg <= emit_reg + 3'd1;
                        if (emit_reg == 3'd7)
                        begin
                            fill_reg  <= '0;
                            bits_reg  <= '0;
                            final_reg <= 1'b0;
                            for (int i = 0; i < 8; i++)
                            begin
                                chain_reg[i] <= sha256_pkg::init_h(3'(i));
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Assertions.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sha256_pkg::ST_IDLE) |-> in_stall)
        else $error("input accepted while busy");
    a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sha256_pkg::ST_ROUND) ##1 (state_reg == sha256_pkg::ST_ROUND)
        |-> (round_reg == 6'd0))
        else $error("compression did not start at round zero");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(emit_reg)))
        else $error("digest beat changed under stall");
    a_emit_after_add: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == sha256_pkg::ST_ADD) && (emit_reg == 3'd0))
        else $error("digest output began out of order");

endmodule

`default_nettype wire
